>>> hw/rtl/lbpe_pkg.sv
// Shared constants for the LED bit pattern expander.
// Used by the channel interfaces and the top level; depends on nothing.
`default_nettype none
package lbpe_pkg;

  // Field widths.
  localparam int unsigned LED_BITS    = 8;
  localparam int unsigned SER_BITS    = 8;
  localparam int unsigned PAT_BITS    = 32;
  localparam int unsigned LEN_W       = 6;
  localparam int unsigned PIDX_W      = $clog2(PAT_BITS);
  localparam int unsigned LED_IDX_W   = $clog2(LED_BITS);
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned CFG_DATA_W  = 32;

  // Longest pattern that the datapath supports.
  localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(PAT_BITS);

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ZERO_PATTERN   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ONE_PATTERN    = 2'd2;

  // Register reset values.
  localparam logic [LEN_W-1:0]    RST_PATTERN_LENGTH = 6'd3;
  localparam logic [PAT_BITS-1:0] RST_ZERO_PATTERN   = 32'd4;
  localparam logic [PAT_BITS-1:0] RST_ONE_PATTERN    = 32'd6;

endpackage : lbpe_pkg
`default_nettype wire

>>> hw/rtl/lbpe_in_if.sv
// Input channel: one LED colour word per handshake.
// Depends on lbpe_pkg for the field width.
`default_nettype none
interface lbpe_in_if;
  logic                          valid;
  logic                          ready;
  logic [lbpe_pkg::LED_BITS-1:0] led_byte;

  modport source (output valid, output led_byte, input ready);
  modport sink   (input valid, input led_byte, output ready);
endinterface : lbpe_in_if
`default_nettype wire

>>> hw/rtl/lbpe_out_if.sv
// Result channel: one packed serial word per handshake, with end-of-run flag.
// Depends on lbpe_pkg for the field width.
`default_nettype none
interface lbpe_out_if;
  logic                          valid;
  logic                          ready;
  logic [lbpe_pkg::SER_BITS-1:0] serial_byte;
  logic                          run_end;

  modport source (output valid, output serial_byte, output run_end, input ready);
  modport sink   (input valid, input serial_byte, input run_end, output ready);
endinterface : lbpe_out_if
`default_nettype wire

>>> hw/rtl/lbpe_cfg_if.sv
// Configuration write channel: register index and write data per word.
// Depends on lbpe_pkg for the field widths.
`default_nettype none
interface lbpe_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [lbpe_pkg::CFG_IDX_W-1:0]  index;
  logic [lbpe_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface : lbpe_cfg_if
`default_nettype wire

>>> hw/rtl/led_bit_pattern_expander.sv
// LED bit pattern expander: replaces each LED bit by an N-bit pattern, packs to words.
// A taken input word loads the work stage, which then fills the output register.
// Throughput: one output word per cycle while the result channel is ready; each input word
// yields N = min(pattern_length, 32) words; with N equal to zero it is taken and yields none.
// Reset (rst_n low, synchronous) restores the registers to 3, 4 and 6 and empties the block.
// Depends on lbpe_pkg, lbpe_in_if, lbpe_out_if and lbpe_cfg_if.
`default_nettype none
module led_bit_pattern_expander (
  input  wire         clk,
  input  wire         rst_n,
  lbpe_in_if.sink     in_if,
  lbpe_out_if.source  out_if,
  lbpe_cfg_if.sink    cfg_if
);

  localparam int unsigned LB  = lbpe_pkg::LED_BITS;
  localparam int unsigned SB  = lbpe_pkg::SER_BITS;
  localparam int unsigned PB  = lbpe_pkg::PAT_BITS;
  localparam int unsigned LW  = lbpe_pkg::LEN_W;
  localparam int unsigned PW  = lbpe_pkg::PIDX_W;
  localparam int unsigned BW  = lbpe_pkg::LED_IDX_W;

  // Configuration registers.
  logic [LW-1:0] pattern_length_r;
  logic [PB-1:0] zero_pattern_r;
  logic [PB-1:0] one_pattern_r;

  // Work stage: the word being expanded and the position within it.
  logic          busy_r,   busy_nxt;
  logic [LB-1:0] led_r,    led_nxt;
  logic [BW-1:0] bidx_r,   bidx_nxt;
  logic [PW-1:0] pidx_r,   pidx_nxt;
  logic [PW-1:0] wcnt_r,   wcnt_nxt;

  // Output register.
  logic          ovalid_r, ovalid_nxt;
  logic [SB-1:0] obyte_r,  obyte_nxt;
  logic          oend_r,   oend_nxt;

  logic [LW-1:0] n_eff;
  logic [PW-1:0] n_m1;
  logic          len_zero;
  logic          out_free;
  logic          produce;
  logic          last_word;
  logic          in_take;
  logic [SB-1:0] step_byte;
  logic [BW-1:0] step_bidx;
  logic [PW-1:0] step_pidx;

  // Configuration writes are always accepted; unknown indexes are dropped.
  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pattern_length_r <= lbpe_pkg::RST_PATTERN_LENGTH;
      zero_pattern_r   <= lbpe_pkg::RST_ZERO_PATTERN;
      one_pattern_r    <= lbpe_pkg::RST_ONE_PATTERN;
    end else if (cfg_if.valid) begin
      case (cfg_if.index)
        lbpe_pkg::REG_PATTERN_LENGTH: pattern_length_r <= cfg_if.data[LW-1:0];
        lbpe_pkg::REG_ZERO_PATTERN:   zero_pattern_r   <= cfg_if.data[PB-1:0];
        lbpe_pkg::REG_ONE_PATTERN:    one_pattern_r    <= cfg_if.data[PB-1:0];
        default: ;
      endcase
    end
  end

  // Effective pattern length, saturated at the datapath maximum.
  assign n_eff    = (pattern_length_r > lbpe_pkg::MAX_LEN) ? lbpe_pkg::MAX_LEN
                                                           : pattern_length_r;
  assign n_m1     = PW'(n_eff - LW'(1));
  assign len_zero = (n_eff == '0);

  // Build eight serial bits, walking pattern bits and LED bits MSB first.
  always_comb begin
    logic [BW-1:0] b;
    logic [PW-1:0] p;
    logic [PB-1:0] pat;
    b = bidx_r;
    p = pidx_r;
    pat = '0;
    step_byte = '0;
    for (int i = 0; i < SB; i++) begin
      pat = led_r[b] ? one_pattern_r : zero_pattern_r;
      step_byte[SB-1-i] = pat[p];
      if (p == '0) begin
        p = n_m1;
        b = b - BW'(1);
      end else begin
        p = p - PW'(1);
      end
    end
    step_bidx = b;
    step_pidx = p;
  end

  // Handshake control: the work stage emits a word when the output register frees up.
  assign out_free  = !ovalid_r || out_if.ready;
  assign produce   = busy_r && out_free;
  assign last_word = (wcnt_r == n_m1);
  assign in_if.ready = !busy_r || (produce && last_word);
  assign in_take   = in_if.valid && in_if.ready;

  always_comb begin
    busy_nxt   = busy_r;
    led_nxt    = led_r;
    bidx_nxt   = bidx_r;
    pidx_nxt   = pidx_r;
    wcnt_nxt   = wcnt_r;
    ovalid_nxt = ovalid_r;
    obyte_nxt  = obyte_r;
    oend_nxt   = oend_r;

    // Output register drains when taken.
    if (ovalid_r && out_if.ready) begin
      ovalid_nxt = 1'b0;
    end

    // Emit the next packed word.
    if (produce) begin
      ovalid_nxt = 1'b1;
      obyte_nxt  = step_byte;
      oend_nxt   = last_word;
      bidx_nxt   = step_bidx;
      pidx_nxt   = step_pidx;
      wcnt_nxt   = wcnt_r + PW'(1);
      if (last_word) begin
        busy_nxt = 1'b0;
      end
    end

    // Load a new input word; a zero-length pattern yields nothing.
    if (in_take) begin
      busy_nxt = !len_zero;
      led_nxt  = in_if.led_byte;
      bidx_nxt = BW'(LB - 1);
      pidx_nxt = n_m1;
      wcnt_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r   <= 1'b0;
      ovalid_r <= 1'b0;
    end else begin
      busy_r   <= busy_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    led_r   <= led_nxt;
    bidx_r  <= bidx_nxt;
    pidx_r  <= pidx_nxt;
    wcnt_r  <= wcnt_nxt;
    obyte_r <= obyte_nxt;
    oend_r  <= oend_nxt;
  end

  assign out_if.valid       = ovalid_r;
  assign out_if.serial_byte = obyte_r;
  assign out_if.run_end     = oend_r;

endmodule : led_bit_pattern_expander
`default_nettype wire

>>> tb/lbpe_serial_checker.sv
// Checker for the LED bit pattern expander: tracks register writes, predicts the packed
// serial words for every accepted LED word and compares them with the result channel.
// Depends on lbpe_pkg for field widths, register indexes and reset values.
module lbpe_serial_checker (
  input  wire                            clk,
  input  wire                            rst_n,
  input  wire                            in_valid,
  input  wire                            in_ready,
  input  wire [lbpe_pkg::LED_BITS-1:0]   in_led_byte,
  input  wire                            out_valid,
  input  wire                            out_ready,
  input  wire [lbpe_pkg::SER_BITS-1:0]   out_serial_byte,
  input  wire                            out_run_end,
  input  wire                            cfg_valid,
  input  wire                            cfg_ready,
  input  wire [lbpe_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire [lbpe_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                             fail_count,
  output int                             words_pending
);

  typedef struct packed {
    logic [lbpe_pkg::SER_BITS-1:0] serial_byte;
    logic                          run_end;
  } serial_word_t;

  // Serial words still owed by the block, oldest first.
  serial_word_t owed_serial_words[$];

  // Local copy of the block's registers.
  logic [lbpe_pkg::LEN_W-1:0]    shadow_length;
  logic [lbpe_pkg::PAT_BITS-1:0] shadow_zero;
  logic [lbpe_pkg::PAT_BITS-1:0] shadow_one;

  // Expand one LED word into its serial words and queue them.
  function automatic void expand_led_byte(input logic [lbpe_pkg::LED_BITS-1:0] led);
    int                            bits_per_led;
    int                            fill;
    int                            produced;
    int                            b;
    int                            i;
    logic [lbpe_pkg::PAT_BITS-1:0] pat;
    logic [lbpe_pkg::SER_BITS-1:0] acc;
    serial_word_t                  next_word;
    bits_per_led = (shadow_length > lbpe_pkg::MAX_LEN) ? int'(lbpe_pkg::MAX_LEN)
                                                       : int'(shadow_length);
    acc = '0;
    fill = 0;
    produced = 0;
    for (b = lbpe_pkg::LED_BITS - 1; b >= 0; b--) begin
      pat = led[b] ? shadow_one : shadow_zero;
      // Pattern bits go out most significant first, from the top of the used range.
      for (i = bits_per_led - 1; i >= 0; i--) begin
        acc = {acc[lbpe_pkg::SER_BITS-2:0], pat[i]};
        fill++;
        if (fill == lbpe_pkg::SER_BITS) begin
          // Eight LED bits of N pattern bits each make exactly N words; the last one
          // carries the end flag.
          next_word.serial_byte = acc;
          next_word.run_end     = (produced == bits_per_led - 1);
          owed_serial_words     = {owed_serial_words, next_word};
          acc = '0;
          fill = 0;
          produced++;
        end
      end
    end
  endfunction

  always @(posedge clk) begin
    serial_word_t wanted;
    if (!rst_n) begin
      shadow_length = lbpe_pkg::RST_PATTERN_LENGTH;
      shadow_zero   = lbpe_pkg::RST_ZERO_PATTERN;
      shadow_one    = lbpe_pkg::RST_ONE_PATTERN;
      fail_count    = 0;
      owed_serial_words.delete();
    end else begin
      // Register writes; an unmapped index changes nothing.
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          lbpe_pkg::REG_PATTERN_LENGTH:
            shadow_length = cfg_data[lbpe_pkg::LEN_W-1:0];
          lbpe_pkg::REG_ZERO_PATTERN:
            shadow_zero   = cfg_data[lbpe_pkg::PAT_BITS-1:0];
          lbpe_pkg::REG_ONE_PATTERN:
            shadow_one    = cfg_data[lbpe_pkg::PAT_BITS-1:0];
          default: ;
        endcase
      end

      // Compare each accepted result word with the oldest owed one.
      if (out_valid && out_ready) begin
        if (owed_serial_words.size() == 0) begin
          $display("%0t: unexpected serial word: expected none, actual byte %02h end %0b",
                   $time, out_serial_byte, out_run_end);
          fail_count++;
        end else begin
          wanted = owed_serial_words.pop_front();
          if (out_serial_byte !== wanted.serial_byte) begin
            $display("%0t: serial_byte mismatch: expected %02h, actual %02h",
                     $time, wanted.serial_byte, out_serial_byte);
            fail_count++;
          end
          if (out_run_end !== wanted.run_end) begin
            $display("%0t: run_end mismatch: expected %0b, actual %0b",
                     $time, wanted.run_end, out_run_end);
            fail_count++;
          end
        end
      end

      if (in_valid && in_ready) begin
        expand_led_byte(in_led_byte);
      end
    end
    words_pending = owed_serial_words.size();
  end

endmodule : lbpe_serial_checker

>>> tb/testbench.sv
// Top of the LED bit pattern expander testbench: clock, reset, LED word and register
// stimulus, random result back-pressure, and the final verdict.
// Depends on lbpe_pkg, the three channel interfaces, the block and lbpe_serial_checker.
module testbench;

  // Index with no register behind it; writes to it must be ignored.
  localparam logic [lbpe_pkg::CFG_IDX_W-1:0] REG_UNMAPPED = 2'd3;
  // Length of the long receiver hold-off, and the word counts where it starts.
  localparam int HOLD_CYCLES  = 250;
  localparam int HOLD_AT_A    = 600;
  localparam int HOLD_AT_B    = 1500;
  localparam int RANDOM_PHASES = 9;
  localparam int PHASE_WORDS   = 27;

  logic clk = 1'b0;
  logic rst_n;
  int   fail_count;
  int   words_pending;
  int   send_calm;
  int   recv_calm;
  int   words_taken;

  lbpe_in_if  in_ch ();
  lbpe_out_if out_ch ();
  lbpe_cfg_if cfg_ch ();

  led_bit_pattern_expander dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch),
    .cfg_if (cfg_ch)
  );

  lbpe_serial_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_ch.valid),
    .in_ready        (in_ch.ready),
    .in_led_byte     (in_ch.led_byte),
    .out_valid       (out_ch.valid),
    .out_ready       (out_ch.ready),
    .out_serial_byte (out_ch.serial_byte),
    .out_run_end     (out_ch.run_end),
    .cfg_valid       (cfg_ch.valid),
    .cfg_ready       (cfg_ch.ready),
    .cfg_index       (cfg_ch.index),
    .cfg_data        (cfg_ch.data),
    .fail_count      (fail_count),
    .words_pending   (words_pending)
  );

  always #5 clk = ~clk;

  // Wait before the next word: mostly random, sometimes a run of back-to-back words.
  function automatic int draw_gap(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      calm = $urandom_range(8, 40);
      return 0;
    end
    return $urandom_range(0, 14);
  endfunction

  // Offer one LED word and wait for it to be taken; valid stays high afterwards.
  task automatic send_led(input logic [lbpe_pkg::LED_BITS-1:0] led);
    int gap;
    gap = draw_gap(send_calm);
    if (gap > 0) begin
      in_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid    = 1'b1;
    in_ch.led_byte = led;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Stop offering words and let the block drain; zero-length words leave no trace
  // in the checker, so an extra wait after the checker is empty covers them.
  task automatic settle();
    in_ch.valid = 1'b0;
    while (words_pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  // One register write on the configuration channel.
  task automatic write_reg(input logic [lbpe_pkg::CFG_IDX_W-1:0] idx,
                           input logic [lbpe_pkg::CFG_DATA_W-1:0] value);
    cfg_ch.valid = 1'b1;
    cfg_ch.index = idx;
    cfg_ch.data  = value;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  task automatic set_patterns(input int len, input logic [lbpe_pkg::PAT_BITS-1:0] zero_pat,
                              input logic [lbpe_pkg::PAT_BITS-1:0] one_pat);
    settle();
    // Bits above the length field are junk that the block must drop.
    write_reg(lbpe_pkg::REG_PATTERN_LENGTH,
              ($urandom() & ~32'h3F) | lbpe_pkg::CFG_DATA_W'(len));
    write_reg(lbpe_pkg::REG_ZERO_PATTERN, zero_pat);
    write_reg(lbpe_pkg::REG_ONE_PATTERN, one_pat);
  endtask

  // Result side: random stalls per word, plus two long hold-offs to fill the block.
  initial begin
    int gap;
    out_ch.ready = 1'b0;
    words_taken  = 0;
    recv_calm    = 0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      gap = draw_gap(recv_calm);
      if (words_taken == HOLD_AT_A || words_taken == HOLD_AT_B) begin
        gap = HOLD_CYCLES;
      end
      if (gap > 0) begin
        out_ch.ready = 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ch.ready = 1'b1;
      @(posedge clk);
      while (!out_ch.valid) @(posedge clk);
      words_taken++;
      @(negedge clk);
    end
  end

  // Run limit.
  initial begin
    #8000000;
    $display("testbench failed");
    $finish;
  end

  // Stimulus and verdict.
  initial begin
    int phase;
    int len;
    int pick;
    int count;
    rst_n           = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.led_byte  = '0;
    cfg_ch.valid    = 1'b0;
    cfg_ch.index    = lbpe_pkg::REG_PATTERN_LENGTH;
    cfg_ch.data     = '0;
    send_calm       = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Reset patterns: all zeros, all ones, single-bit words and two mixed words.
    send_led(8'h00);
    send_led(8'hFF);
    send_led(8'h80);
    send_led(8'h01);
    send_led(8'hA5);
    send_led(8'h5A);

    // Shortest pattern, with junk in the unused pattern bits.
    set_patterns(1, 32'hFFFF_FFFE, 32'h0000_0001);
    send_led(8'h00);
    send_led(8'hFF);
    send_led(8'h3C);

    // Longest pattern: 32 words per LED word.
    set_patterns(32, 32'hFFFF_FFFF, 32'h0000_0000);
    send_led(8'h00);
    send_led(8'hFF);
    send_led(8'h96);

    // Zero length: LED words are taken but yield nothing.
    set_patterns(0, 32'h1357_9BDF, 32'h2468_ACE0);
    send_led(8'h12);
    send_led(8'hFF);

    // Overlong lengths saturate to 32.
    set_patterns(63, 32'hA5A5_0F0F, 32'h1234_5678);
    send_led(8'hC3);
    send_led(8'h7E);
    set_patterns(33, 32'h8000_0001, 32'h7FFF_FFFE);
    send_led(8'h00);

    // A write to the unmapped index must leave the registers alone.
    set_patterns(8, 32'hFFFF_FF00, 32'h0000_00FF);
    write_reg(REG_UNMAPPED, 32'hFFFF_FFFF);
    send_led(8'h81);
    send_led(8'h42);

    // Random phases, mostly short patterns, now and then the extremes.
    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      pick = $urandom_range(0, 9);
      case (pick)
        0:       len = 0;
        1:       len = 32;
        2:       len = $urandom_range(33, 63);
        default: len = $urandom_range(1, 8);
      endcase
      set_patterns(len, $urandom(), $urandom());
      count = (len == 0) ? 4 : PHASE_WORDS;
      repeat (count) send_led(lbpe_pkg::LED_BITS'($urandom_range(0, 255)));
    end

    // Drain, then give the block time to show any stray word.
    in_ch.valid = 1'b0;
    while (words_pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (fail_count == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule : testbench
